// File: design/pctdec_pkg.sv
`timescale 1ns / 1ps
// Package for the percent decoder: character codes, escape phase type,
// output bundle type and hex digit helper. No dependencies.
package pctdec_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int MAX_OUT = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // Results caused by one input byte, cnt is 1..3.
    typedef struct packed {
        logic [1:0]              cnt;
        logic [MAX_OUT-1:0][7:0] bytes;
        logic                    last;
    } t_bundle;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            h.nib = 4'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            h.nib = 4'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            h.nib = 4'(c - CH_UA + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: design/pctdec_front.sv
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks the escape state and builds the
// bundle of output bytes for each one. Depends on pctdec_pkg.
module pctdec_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_plus_as_space,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic                i_q_full,
    output logic                o_push,
    output pctdec_pkg::t_bundle o_bundle
);
    import pctdec_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        t_hex       hb;
        t_hex       hh;
        logic [1:0] n;
        logic       run_ord;

        hb       = hex_decode(i_byte);
        hh       = hex_decode(r_held);
        n        = 2'd0;
        run_ord  = 1'b0;
        n_phase  = PH_IDLE;
        n_held   = r_held;
        o_bundle = '0;

        unique case (r_phase)
            PH_PCT: begin
                if (hb.ok) begin
                    if (i_last) begin
                        o_bundle.bytes[0] = CH_PERCENT;
                        o_bundle.bytes[1] = i_byte;
                        n = 2'd2;
                    end else begin
                        n_held  = i_byte;
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    o_bundle.bytes[0] = CH_PERCENT;
                    n = 2'd1;
                    run_ord = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (hb.ok) begin
                    o_bundle.bytes[0] = {hh.nib, hb.nib};
                    n = 2'd1;
                end else begin
                    o_bundle.bytes[0] = CH_PERCENT;
                    o_bundle.bytes[1] = r_held;
                    n = 2'd2;
                    run_ord = 1'b1;
                end
            end
            default: begin
                run_ord = 1'b1;
            end
        endcase

        if (run_ord) begin
            if (i_byte == CH_PERCENT) begin
                if (i_last) begin
                    o_bundle.bytes[n] = CH_PERCENT;
                    n = n + 2'd1;
                end else begin
                    n_phase = PH_PCT;
                end
            end else if (i_plus_as_space && i_byte == CH_PLUS) begin
                o_bundle.bytes[n] = CH_SPACE;
                n = n + 2'd1;
            end else begin
                o_bundle.bytes[n] = i_byte;
                n = n + 2'd1;
            end
        end

        if (i_last) begin
            n_phase = PH_IDLE;
        end

        o_bundle.cnt  = n;
        o_bundle.last = i_last;
        o_push        = accept && (n != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// File: design/pctdec_queue.sv
`timescale 1ns / 1ps
// Short bundle queue between the front and back ends.
// Depends on pctdec_pkg.
module pctdec_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pctdec_pkg::t_bundle i_din,
    output logic                o_full,
    input  logic                i_pop,
    output pctdec_pkg::t_bundle o_dout,
    output logic                o_empty
);
    import pctdec_pkg::*;

    t_bundle        r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_dout  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

// File: design/pctdec_back.sv
`timescale 1ns / 1ps
// Back end: unpacks queued bundles into single output bytes through an
// output register. Depends on pctdec_pkg.
module pctdec_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pctdec_pkg::t_bundle i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);
    import pctdec_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       final_byte;

    assign load       = !i_empty && (!r_valid || i_ready);
    assign final_byte = (r_idx == i_head.cnt - 2'd1);
    assign o_pop      = load && final_byte;

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= i_head.last && final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_byte ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_head.cnt))
        else $error("bundle index past bundle size");

    a_idx_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_idx == 2'd0))
        else $error("bundle index left set with empty queue");

endmodule

// File: design/percent_decoder_core.sv
`timescale 1ns / 1ps
// URL percent decoder top level: APB register, front end, queue, back end.
// Depends on pctdec_pkg, pctdec_front, pctdec_queue, pctdec_back.
//
// Usage:
//  - s_axis carries encoded string bytes, tlast on the final byte of a string.
//  - m_axis carries decoded bytes, tlast on the final byte of each string.
//  - "%hh" (either case) decodes to one byte; a broken escape is passed raw;
//    with plus_as_space set, '+' becomes ' '. Escapes cut off by tlast are
//    flushed raw.
//  - APB register 0 (address 0): bit 0 plus_as_space. Write only while idle.
// Timing:
//  - A byte accepted on s_axis is written into the bundle queue, then loaded
//    into the back-end output register, which drives m_axis.
//  - One input transaction per cycle while the queue has room, one output
//    transaction per cycle while m_axis is ready; the back end sends one
//    bundle byte per cycle; a four-entry bundle queue decouples the two sides.
//  - When m_axis stalls the queue fills and s_axis_tready drops once it holds
//    four bundles.
// Reset: escape state idle, queue and output register empty, register 0.
module percent_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);
    import pctdec_pkg::*;

    localparam logic REG_PLUS = 1'b0;

    logic    r_plus_as_space;
    logic    q_full, q_empty, q_push, q_pop;
    t_bundle q_din, q_dout;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PLUS) ? {31'd0, r_plus_as_space} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_as_space <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PLUS) begin
            r_plus_as_space <= pwdata[0];
        end
    end

    pctdec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_plus_as_space (r_plus_as_space),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_byte          (s_axis_tdata),
        .i_last          (s_axis_tlast),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_bundle        (q_din)
    );

    pctdec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_din   (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_empty (q_empty)
    );

    pctdec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_dout),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// File: dv/tb_percent_decoder_core.sv
`timescale 1ns / 1ps
// Testbench for percent_decoder_core: directed and random strings with a
// scoreboard class that predicts the decoded stream. Depends on pctdec_pkg.
module tb_percent_decoder_core;
    import pctdec_pkg::*;

    localparam int unsigned REG_PLUS_AS_SPACE = 0;
    localparam int unsigned REG_UNUSED        = 1;
    localparam int unsigned STALL_LIMIT       = 2000;
    localparam int unsigned DRAIN_CYCLES      = 12;
    localparam int unsigned HOLD_CYCLES       = 120;
    localparam int unsigned ITEMS_PER_PHASE   = 130;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_out;

    class decode_scoreboard;
        t_phase      phase;
        logic [7:0]  held;
        logic        plus_to_space;
        t_dec_out    expected_q[$];
        logic [7:0]  step_q[$];
        int unsigned errors;

        function new();
            phase         = PH_IDLE;
            held          = 8'd0;
            plus_to_space = 1'b0;
            errors        = 0;
        endfunction

        function void write_reg(int unsigned index, logic [31:0] value);
            if (index == REG_PLUS_AS_SPACE) plus_to_space = value[0];
        endfunction

        function void add_out(logic [7:0] b);
            step_q.insert(step_q.size(), b);
        endfunction

        function bit is_hex(logic [7:0] c);
            return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
                   (c >= CH_UA && c <= CH_UF);
        endfunction

        function logic [3:0] nibble(logic [7:0] c);
            logic [7:0] v;
            if (c >= CH_0 && c <= CH_9) v = c - CH_0;
            else if (c >= CH_LA && c <= CH_LF) v = c - CH_LA + 8'd10;
            else v = c - CH_UA + 8'd10;
            return v[3:0];
        endfunction

        function void plain(logic [7:0] b, logic last);
            if (b == CH_PERCENT) begin
                if (last) add_out(CH_PERCENT);
                else phase = PH_PCT;
            end else if (plus_to_space && b == CH_PLUS) begin
                add_out(CH_SPACE);
            end else begin
                add_out(b);
            end
        endfunction

        function void predict_bytes(logic [7:0] b, logic last);
            t_dec_out o;
            step_q.delete();
            case (phase)
                PH_PCT: begin
                    if (is_hex(b)) begin
                        if (last) begin
                            add_out(CH_PERCENT);
                            add_out(b);
                            phase = PH_IDLE;
                        end else begin
                            held  = b;
                            phase = PH_DIGIT;
                        end
                    end else begin
                        phase = PH_IDLE;
                        add_out(CH_PERCENT);
                        plain(b, last);
                    end
                end
                PH_DIGIT: begin
                    phase = PH_IDLE;
                    if (is_hex(b)) begin
                        add_out({nibble(held), nibble(b)});
                    end else begin
                        add_out(CH_PERCENT);
                        add_out(held);
                        plain(b, last);
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    plain(b, last);
                end
            endcase
            if (last) phase = PH_IDLE;
            foreach (step_q[i]) begin
                o.data = step_q[i];
                o.last = last && (i == step_q.size() - 1);
                expected_q.insert(expected_q.size(), o);
            end
        endfunction

        function void check_decoded(logic [7:0] b, logic last);
            t_dec_out e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output byte 0x%02h last %0b", $time, b, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (e.data !== b) begin
                $display("%0t: out_byte expected 0x%02h actual 0x%02h", $time, e.data, b);
                errors++;
            end
            if (e.last !== last) begin
                $display("%0t: out_last expected %0b actual %0b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] out_byte
    logic        m_axis_tlast;

    decode_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_ack      = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_cycles  = 0;

    percent_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_decoded(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic apb_write(input int unsigned index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(index * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(index, data);
    endtask

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_bytes(b, last);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char();
        int unsigned r;
        r = $urandom_range(21);
        if (r < 10) return CH_0 + 8'(r);
        if (r < 16) return CH_LA + 8'(r - 10);
        return CH_UA + 8'(r - 16);
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        logic [7:0]  near_hex [6];
        near_hex = '{CH_0 - 8'd1, CH_9 + 8'd1, CH_UA - 8'd1, CH_UF + 8'd1,
                     CH_LA - 8'd1, CH_LF + 8'd1};
        r = $urandom_range(99);
        if (r < 35) return hex_char();
        if (r < 50) return CH_PERCENT;
        if (r < 60) return CH_PLUS;
        if (r < 70) return near_hex[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        logic [7:0]  str_q[$];
        sent = 0;
        while (sent < n_items) begin
            str_q.delete();
            len = $urandom_range(1, 12);
            if ($urandom_range(9) == 0) begin
                repeat (len) str_q.insert(str_q.size(), 8'($urandom_range(255)));
            end else begin
                while (str_q.size() < len) begin
                    r = $urandom_range(99);
                    if (r < 45) begin
                        str_q.insert(str_q.size(), CH_PERCENT);
                        str_q.insert(str_q.size(), hex_char());
                        str_q.insert(str_q.size(), hex_char());
                    end else if (r < 55) begin
                        str_q.insert(str_q.size(), CH_PERCENT);
                        if ($urandom_range(1)) str_q.insert(str_q.size(), hex_char());
                        str_q.insert(str_q.size(), pick_byte());
                    end else begin
                        str_q.insert(str_q.size(), pick_byte());
                    end
                end
            end
            foreach (str_q[i]) send_item(str_q[i], i == str_q.size() - 1);
            sent += str_q.size();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 27;
        recv_idle_pct <= 56;
        apb_write(REG_PLUS_AS_SPACE, 32'd0);

        send_string("%41");
        send_string("%6a%Ff");
        send_string("%9/");
        send_string("%%0:");
        send_string("%");
        send_string("%A");
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        wait_idle();
        apb_write(REG_PLUS_AS_SPACE, {31'($urandom), 1'b1});
        send_string("+%+%F+");
        run_random(ITEMS_PER_PHASE);

        wait_idle();
        apb_write(REG_UNUSED, 32'($urandom));
        apb_write(REG_PLUS_AS_SPACE, 32'd0);
        send_idle_pct = 56;
        recv_idle_pct <= 27;
        run_random(ITEMS_PER_PHASE);

        wait_idle();
        apb_write(REG_PLUS_AS_SPACE, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req <= hold_req + 1;
        run_random(ITEMS_PER_PHASE / 2);

        wait_idle();
        apb_write(REG_PLUS_AS_SPACE, {31'($urandom), 1'b0});
        run_random(ITEMS_PER_PHASE / 2);
        wait_idle();

        if (sb.expected_q.size() != 0)
            $display("%0t: %0d expected bytes never arrived", $time, sb.expected_q.size());
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
design/pctdec_pkg.sv
design/pctdec_front.sv
design/pctdec_queue.sv
design/pctdec_back.sv
design/percent_decoder_core.sv
dv/tb_percent_decoder_core.sv
